// ===== sv/sha1_pkg.sv =====
// Shared types and constants for the SHA-1 hash engine.
`default_nettype none

package sha1_pkg;

  localparam int NUM_WORDS  = 5;
  localparam int NUM_ROUNDS = 80;

  typedef logic [NUM_WORDS-1:0][31:0] word5_t;

  localparam word5_t INIT_CHAIN = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_FILL  = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [3:0] LEN_BYTES = 4'd8;
  localparam logic [2:0] LAST_IDX  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic push;
    logic start;
  } core_ctl_t;

endpackage

`default_nettype wire

// ===== sv/sha1_if.sv =====
// Valid/ready channel interfaces for the SHA-1 hash engine.
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ===== sv/sha1_core.sv =====
// Block buffer, message schedule and shared round unit of the SHA-1 engine.
`default_nettype none

module sha1_core import sha1_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire core_ctl_t  ctl,
  input  wire logic [7:0] push_byte,
  input  wire word5_t     chain_in,
  output word5_t          work,
  output logic            done
);

  localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

  logic [511:0] blk_r;
  word5_t       work_r;
  logic [6:0]   rnd_r;
  logic         run_r;
  logic         done_r;

  logic [31:0] w0, w2, w8, w13, w_new;
  logic [31:0] f_val, k_val, t_sum;
  logic [31:0] a, b, c, d, e;

  assign w0  = blk_r[511:480];
  assign w2  = blk_r[447:416];
  assign w8  = blk_r[255:224];
  assign w13 = blk_r[95:64];

  always_comb begin
    logic [31:0] x;
    x     = w13 ^ w8 ^ w2 ^ w0;
    w_new = {x[30:0], x[31]};
  end

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = 32'h8F1BBCDC;
    end else begin
      f_val = b ^ c ^ d;
      k_val = 32'hCA62C1D6;
    end
    t_sum = {a[26:0], a[31:27]} + f_val + e + k_val + w0;
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      blk_r <= {blk_r[503:0], push_byte};
    end else if (run_r) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      work_r <= chain_in;
    end else if (run_r) begin
      work_r <= {d, c, {b[1:0], b[31:2]}, a, t_sum};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (rnd_r == LAST_ROUND);
      if (ctl.start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign work = work_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== sv/sha1_hash.sv =====
// Top level of the SHA-1 hash engine over a byte stream.
//
//   Channel   Dir   Carries
//   in_ch     in    kind, data_byte: one message byte or the end-of-message mark
//   out_ch    out   digest_word, word_index, last_word: five beats per digest
//
// The 64th message byte of a block starts the shared round unit, which runs 80 rounds
// at one per cycle and then folds the result into the chaining words. The end mark
// adds 9 to 72 padding bytes and one or two compressions, then five output beats.
// Input is held off while rounds, padding or output run.
// Reset is synchronous and returns the chaining words to the initial constants.
`default_nettype none

module sha1_hash import sha1_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha1_in_if.sink     in_ch,
  sha1_out_if.source  out_ch
);

  state_t      state_r, state_nxt;
  word5_t      chain_r;
  logic [5:0]  fill_r;
  logic [63:0] cnt_r;
  logic        mark_r;
  logic [3:0]  len_cnt_r;
  logic [2:0]  idx_r;

  core_ctl_t   ctl;
  logic [7:0]  push_byte;
  word5_t      work;
  logic        done;

  logic in_acc, out_acc, len_phase, blk_full;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign len_phase = mark_r && ((fill_r == LEN_FILL) || (len_cnt_r != '0));

  always_comb begin
    ctl.push  = 1'b0;
    push_byte = in_ch.data_byte;
    if ((state_r == ST_IDLE) && in_acc && (in_ch.kind == KIND_BYTE)) begin
      ctl.push = 1'b1;
    end else if (state_r == ST_PAD) begin
      ctl.push = 1'b1;
      if (!mark_r) begin
        push_byte = PAD_MARK;
      end else if (len_phase) begin
        push_byte = cnt_r[63:56];
      end else begin
        push_byte = '0;
      end
    end
    blk_full  = ctl.push && (fill_r == LAST_FILL);
    ctl.start = blk_full;
  end

  sha1_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .push_byte (push_byte),
    .chain_in  (chain_r),
    .work      (work),
    .done      (done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == KIND_END) begin
            state_nxt = ST_PAD;
          end else if (blk_full) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (done) begin
          if (!mark_r) begin
            state_nxt = ST_IDLE;
          end else if (len_cnt_r == LEN_BYTES) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (out_acc && (idx_r == LAST_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready        = (state_r == ST_IDLE);
    out_ch.valid       = (state_r == ST_OUT);
    out_ch.digest_word = chain_r[idx_r];
    out_ch.word_index  = idx_r;
    out_ch.last_word   = (idx_r == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chain_r   <= INIT_CHAIN;
      fill_r    <= '0;
      cnt_r     <= '0;
      mark_r    <= 1'b0;
      len_cnt_r <= '0;
      idx_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.push) begin
        fill_r <= fill_r + 6'd1;
      end
      if ((state_r == ST_IDLE) && ctl.push) begin
        cnt_r <= cnt_r + 64'd8;
      end
      if (state_r == ST_PAD) begin
        if (!mark_r) begin
          mark_r <= 1'b1;
        end else if (len_phase) begin
          cnt_r     <= {cnt_r[55:0], 8'h00};
          len_cnt_r <= len_cnt_r + 4'd1;
        end
      end
      if ((state_r == ST_ROUND) && done) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain_r[i] <= chain_r[i] + work[i];
        end
        idx_r <= '0;
      end
      if (out_acc) begin
        if (idx_r == LAST_IDX) begin
          chain_r   <= INIT_CHAIN;
          fill_r    <= '0;
          cnt_r     <= '0;
          mark_r    <= 1'b0;
          len_cnt_r <= '0;
          idx_r     <= '0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sha1_hash_checker.sv =====
// Port-level checks for the SHA-1 hash engine and their binding to the top level.
`default_nettype none

module sha1_hash_checker import sha1_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_word,
  input wire logic [2:0]  out_index,
  input wire logic        out_last
);

  // The engine never takes input while a digest is being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest beats pending");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_index == LAST_IDX)))
    else $error("last_word does not match word_index");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_index == $past(out_index) + 3'd1)))
    else $error("digest beats not consecutive");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("engine not idle after final digest beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled digest beat changed");

endmodule

bind sha1_hash sha1_hash_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.digest_word),
  .out_index (out_ch.word_index),
  .out_last  (out_ch.last_word)
);

`default_nettype wire
